[src/lpcd_pkg.sv]
`default_nettype none
package lpcd_pkg;

	// Key table: 1 + 3 + ... + 127 entries for code lengths 1..7.
	localparam int unsigned TableEntries = 247;
	localparam int unsigned TableDepth   = 256;
	localparam int unsigned AddrBits     = 8;
	localparam int unsigned CharBits     = 8;
	localparam int unsigned MaxCodeLen   = 7;
	localparam int unsigned ShiftBits    = 7;
	localparam int unsigned CountBits    = 3;

	localparam logic [CharBits-1:0] NewlineChar = 8'd10;

	typedef enum logic [1:0] {
		PH_LOAD = 2'd0,
		PH_LEN  = 2'd1,
		PH_CODE = 2'd2,
		PH_END  = 2'd3
	} phase_t;

	typedef enum logic {
		FUNC_HEADER = 1'b0,
		FUNC_BIT    = 1'b1
	} func_t;

	typedef struct packed {
		logic                func;
		logic [CharBits-1:0] header_char;
		logic                code_bit;
	} in_t;

	typedef struct packed {
		logic [CharBits-1:0] out_char;
		logic                end_of_message;
	} out_t;

endpackage
`default_nettype wire

[src/length_prefixed_code_decoder_unit.sv]
`default_nettype none
// Length-prefixed code decoder.
// Input channel (item_valid / item_stall / item): each beat is either a header
// character (func = 0) appended to the key table, or one code bit (func = 1),
// MSB first. Output channel (result_valid / result_stall / result): one beat
// per decoded character, and a newline with end_of_message set when a zero
// segment length closes the message.
// A result beat is registered in the read stage, where the key table is read,
// and then in the output register, after the input beat that completes its
// code. Throughput: one input beat per clock while item_stall is low, set by
// the combinational decode state update and the one-read/one-write table port.
// Beats that give no result still pass through one clock each.
// Reset clears the decode state and load count; the table contents stay
// undefined and are only read below the load count.
// When the receiver stalls, the output register holds its beat; one more
// result can wait in the read stage, after which item_stall rises and the
// input is held until the output drains.
module length_prefixed_code_decoder_unit #(
	parameter int unsigned LENGTH_FIELD_BITS = 3
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire lpcd_pkg::in_t item,
	output logic               result_valid,
	input  wire logic          result_stall,
	output lpcd_pkg::out_t     result
);

	localparam logic [lpcd_pkg::CountBits-1:0] LenBits =
		lpcd_pkg::CountBits'(LENGTH_FIELD_BITS);

	// decode state
	lpcd_pkg::phase_t                  phase_q, phase_nxt;
	logic [lpcd_pkg::AddrBits-1:0]     load_count_q, load_count_nxt;
	logic [lpcd_pkg::CountBits-1:0]    seg_len_q, seg_len_nxt;
	logic [lpcd_pkg::CountBits-1:0]    bits_q, bits_nxt;
	logic [lpcd_pkg::ShiftBits-1:0]    shift_q, shift_nxt;

	// per-beat decisions
	logic                              accept;
	logic                              wr_en;
	logic [lpcd_pkg::AddrBits-1:0]     wr_addr;
	logic                              emit;
	logic                              emit_eom;
	logic                              emit_hit;
	logic [lpcd_pkg::AddrBits-1:0]     rd_addr;

	// working values inside the bit update
	logic [lpcd_pkg::CountBits-1:0]    bits_w;
	logic [lpcd_pkg::ShiftBits-1:0]    shift_w;
	logic [lpcd_pkg::ShiftBits-1:0]    ones_w;
	logic [lpcd_pkg::AddrBits-1:0]     pos_w;
	logic [LENGTH_FIELD_BITS-1:0]      len_field;
	logic                              len_done;
	logic                              code_done;
	logic                              code_close;

	// read stage and output register
	logic                              valid_s1;
	logic                              eom_s1;
	logic                              hit_s1;
	logic [lpcd_pkg::CharBits-1:0]     rdata_s1;
	logic                              advance;

	logic [lpcd_pkg::CharBits-1:0]     key_mem [lpcd_pkg::TableDepth];

	assign advance    = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	// shift register and counter after this bit; a bit while loading starts
	// from a cleared decoder
	always_comb begin
		if (phase_q == lpcd_pkg::PH_LOAD) begin
			shift_w = {{(lpcd_pkg::ShiftBits-1){1'b0}}, item.code_bit};
			bits_w  = lpcd_pkg::CountBits'(1);
		end else begin
			shift_w = {shift_q[lpcd_pkg::ShiftBits-2:0], item.code_bit};
			bits_w  = bits_q + lpcd_pkg::CountBits'(1);
		end
		len_field  = shift_w[LENGTH_FIELD_BITS-1:0];
		len_done   = (bits_w == LenBits);
		code_done  = (bits_w == seg_len_q);
		ones_w     = lpcd_pkg::ShiftBits'((8'd1 << seg_len_q) - 8'd1);
		code_close = (shift_w == ones_w);
		pos_w      = lpcd_pkg::AddrBits'({1'b0, ones_w})
			- lpcd_pkg::AddrBits'(seg_len_q)
			+ lpcd_pkg::AddrBits'(shift_w);
	end

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		if (item.func == lpcd_pkg::FUNC_HEADER) begin
			phase_nxt = lpcd_pkg::PH_LOAD;
		end else begin
			unique case (phase_q) inside
				lpcd_pkg::PH_LOAD, lpcd_pkg::PH_LEN: begin
					if (len_done) begin
						phase_nxt = (len_field == '0) ? lpcd_pkg::PH_END
							: lpcd_pkg::PH_CODE;
					end else begin
						phase_nxt = lpcd_pkg::PH_LEN;
					end
				end
				lpcd_pkg::PH_CODE: begin
					if (code_done && code_close) begin
						phase_nxt = lpcd_pkg::PH_LEN;
					end
				end
				lpcd_pkg::PH_END: phase_nxt = lpcd_pkg::PH_END;
				default: phase_nxt = lpcd_pkg::PH_LOAD;
			endcase
		end
	end

	// datapath updates and outputs of the decode step
	always_comb begin
		load_count_nxt = load_count_q;
		seg_len_nxt    = seg_len_q;
		bits_nxt       = bits_q;
		shift_nxt      = shift_q;
		wr_en          = 1'b0;
		wr_addr        = load_count_q;
		emit           = 1'b0;
		emit_eom       = 1'b0;
		emit_hit       = 1'b0;
		rd_addr        = pos_w;
		if (item.func == lpcd_pkg::FUNC_HEADER) begin
			if (phase_q != lpcd_pkg::PH_LOAD) begin
				// restart loading at entry 0
				wr_en          = 1'b1;
				wr_addr        = '0;
				load_count_nxt = lpcd_pkg::AddrBits'(1);
				seg_len_nxt    = '0;
				bits_nxt       = '0;
				shift_nxt      = '0;
			end else if (load_count_q < lpcd_pkg::AddrBits'(lpcd_pkg::TableEntries)) begin
				wr_en          = 1'b1;
				load_count_nxt = load_count_q + lpcd_pkg::AddrBits'(1);
			end
		end else begin
			unique case (phase_q) inside
				lpcd_pkg::PH_LOAD, lpcd_pkg::PH_LEN: begin
					bits_nxt  = bits_w;
					shift_nxt = shift_w;
					if (phase_q == lpcd_pkg::PH_LOAD) begin
						seg_len_nxt = '0;
					end
					if (len_done) begin
						bits_nxt  = '0;
						shift_nxt = '0;
						if (len_field == '0) begin
							seg_len_nxt = '0;
							emit        = 1'b1;
							emit_eom    = 1'b1;
						end else if ({1'b0, len_field} >
							(LENGTH_FIELD_BITS+1)'(lpcd_pkg::MaxCodeLen)) begin
							seg_len_nxt = lpcd_pkg::CountBits'(lpcd_pkg::MaxCodeLen);
						end else begin
							seg_len_nxt = lpcd_pkg::CountBits'(len_field);
						end
					end
				end
				lpcd_pkg::PH_CODE: begin
					bits_nxt  = bits_w;
					shift_nxt = shift_w;
					if (code_done) begin
						bits_nxt  = '0;
						shift_nxt = '0;
						if (code_close) begin
							seg_len_nxt = '0;
						end else begin
							emit     = 1'b1;
							emit_hit = (pos_w < load_count_q);
						end
					end
				end
				lpcd_pkg::PH_END: ;
				default: ;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= lpcd_pkg::PH_LOAD;
			load_count_q <= '0;
			seg_len_q    <= '0;
			bits_q       <= '0;
			shift_q      <= '0;
		end else if (accept) begin
			phase_q      <= phase_nxt;
			load_count_q <= load_count_nxt;
			seg_len_q    <= seg_len_nxt;
			bits_q       <= bits_nxt;
			shift_q      <= shift_nxt;
		end
	end

	// key table: one write port, one registered read port; a write and a read
	// of the same entry never meet, since a code needs several bits after
	// the last header character
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			key_mem[wr_addr] <= item.header_char;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit_hit) begin
			rdata_s1 <= key_mem[rd_addr];
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			eom_s1   <= 1'b0;
			hit_s1   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= emit;
				eom_s1   <= emit_eom;
				hit_s1   <= emit_hit;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.end_of_message <= eom_s1;
			if (eom_s1) begin
				result.out_char <= lpcd_pkg::NewlineChar;
			end else if (hit_s1) begin
				result.out_char <= rdata_s1;
			end else begin
				result.out_char <= '0;
			end
		end
	end

endmodule
`default_nettype wire
